### src/hlbm_pkg.sv
//------------------------------------------------------------------------------
// hlbm_pkg: shared types and constants
// Action codes and sizing for the hybrid log/block translation table.
//------------------------------------------------------------------------------
`default_nettype none
package hlbm_pkg;
  localparam int unsigned ZonePagesDef = 64;
  localparam int unsigned DataZonesDef = 16;
  localparam int unsigned ZonesDef     = 32;
  localparam int unsigned LogDepth     = 1024;
  localparam int unsigned LpW          = 10;
  localparam int unsigned PpW          = 11;
  localparam int unsigned ZiW          = 5;
  localparam int unsigned CntOutW      = 7;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_MERGE  = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef struct packed {
    logic [PpW-1:0]     page;
    logic               hit;
    logic               miss;
    logic [CntOutW-1:0] count;
  } result_t;
endpackage
`default_nettype wire

### src/hybrid_log_block_map.sv
//------------------------------------------------------------------------------
// hybrid_log_block_map: hybrid log/block flash translation table
// Lookup and query read and evaluate only; a log write also counts up the zone of its
// page, a log write over an existing mapping counts down the superseded page's zone, and
// a merge does one counter update per live log entry. One item at a time: the next one
// is taken once the result leaves. After reset a clearing pass over log and counters runs.
//------------------------------------------------------------------------------
`default_nettype none
module hybrid_log_block_map #(
  parameter int unsigned ZonePages = hlbm_pkg::ZonePagesDef,
  parameter int unsigned DataZones = hlbm_pkg::DataZonesDef,
  parameter int unsigned Zones     = hlbm_pkg::ZonesDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               action_i,
  input  wire logic [hlbm_pkg::LpW-1:0] logical_page_i,
  input  wire logic [hlbm_pkg::PpW-1:0] physical_page_i,
  input  wire logic [hlbm_pkg::ZiW-1:0] zone_index_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [hlbm_pkg::PpW-1:0]      mapped_page_o,
  output logic                          from_log_o,
  output logic                          unmapped_o,
  output logic [hlbm_pkg::CntOutW-1:0]  valid_count_o
);
  import hlbm_pkg::*;

  localparam int unsigned OffW = (ZonePages > 1) ? $clog2(ZonePages) : 1;
  localparam int unsigned ZW   = $clog2(Zones);
  localparam int unsigned CW   = $clog2(ZonePages + 1);
  localparam int unsigned LdW  = $clog2(LogDepth);
  localparam int unsigned BW   = (DataZones > 1) ? $clog2(DataZones) : 1;

  // divide by ZonePages through a reciprocal multiply, exact for PpW-bit operands
  localparam int unsigned RcpSh = PpW + OffW;
  localparam int unsigned PrdW  = 2 * PpW + 1;
  localparam logic [PpW:0] RcpM =
      (PpW+1)'(((64'd1 << RcpSh) + 64'(ZonePages) - 64'd1) / 64'(ZonePages));

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_EVAL = 4'd2,
                         S_UP = 4'd3, S_DNRD = 4'd4, S_DN = 4'd5,
                         S_MRD = 4'd6, S_MEV = 4'd7, S_MCRD = 4'd8,
                         S_MDN = 4'd9, S_OUT = 4'd10, S_CLR = 4'd11,
                         S_WAIT = 4'd12;

  function automatic logic [31:0] zp_div(input logic [PpW-1:0] x);
    logic [PrdW-1:0] prod;
    prod = PrdW'(x) * PrdW'(RcpM);
    return 32'(prod >> RcpSh);
  endfunction

  logic [3:0]     st_q, st_d;
  logic [1:0]     act_q;
  logic [LpW-1:0] lp_q;
  logic [PpW-1:0] pp_q;
  logic [ZiW-1:0] zi_q;
  logic [LdW-1:0] addr_q;
  logic [OffW:0]  ofs_q;
  logic [LdW-1:0] clr_q;
  result_t        res_q, res_d;

  logic           lv [LogDepth];
  logic [PpW-1:0] lpg [LogDepth];
  logic           lv_r;
  logic [PpW-1:0] lpg_r;
  logic           bhz_q [DataZones];
  logic [ZiW-1:0] bz [DataZones];

  logic [31:0]    blk, off, pz, oz, mz;
  logic           blk_ok;
  logic [BW-1:0]  bidx;

  logic           c_rd, c_wr, c_up, c_busy;
  logic [ZW-1:0]  c_rz, c_wz;
  logic [CW-1:0]  c_rdat;

  assign blk    = zp_div(PpW'(lp_q));
  assign off    = 32'(lp_q) - blk * ZonePages;
  assign pz     = zp_div(pp_q);
  assign oz     = zp_div(lpg_r);
  assign blk_ok = blk < DataZones;
  assign bidx   = BW'(blk);
  assign mz     = blk * ZonePages + 32'(ofs_q);

  hlbm_zone_count #(.ZonePages(ZonePages), .Zones(Zones)) u_cnt (
    .clk_i, .rst_ni,
    .rd_i(c_rd), .rd_zone_i(c_rz), .rd_data_o(c_rdat),
    .wr_i(c_wr), .wr_zone_i(c_wz), .up_i(c_up), .wr_old_i(c_rdat),
    .clr_busy_o(c_busy)
  );

  always_comb begin
    c_rd = 1'b0; c_rz = '0; c_wr = 1'b0; c_wz = '0; c_up = 1'b0;
    case (st_q)
      S_RD: begin
        c_rd = 1'b1;
        c_rz = (act_q == ACT_QUERY) ? ZW'(zi_q) : ZW'(pz);
      end
      S_EVAL: begin
        if (act_q == ACT_WRITE && blk_ok && pz < Zones) begin
          c_wr = 1'b1; c_wz = ZW'(pz); c_up = 1'b1;
        end
      end
      S_DNRD, S_MCRD: begin
        c_rd = 1'b1; c_rz = ZW'(oz);
      end
      S_DN, S_MDN: begin
        c_wr = (oz < Zones); c_wz = ZW'(oz);
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_CLR:  if (clr_q == LdW'(LogDepth - 1)) st_d = S_WAIT;
      S_WAIT: if (!c_busy) st_d = S_IDLE;
      S_IDLE: if (in_valid_i) st_d = S_RD;
      S_RD:   st_d = S_EVAL;
      S_EVAL: begin
        st_d = S_OUT;
        if (act_q == ACT_WRITE && blk_ok && pz < Zones && lv_r) st_d = S_DNRD;
        if (act_q == ACT_MERGE && blk_ok && 32'(zi_q) < Zones) st_d = S_MRD;
      end
      S_DNRD: st_d = S_DN;
      S_DN:   st_d = S_OUT;
      S_MRD:  st_d = (ofs_q == (OffW+1)'(ZonePages) || mz >= LogDepth) ? S_OUT : S_MEV;
      S_MEV:  st_d = lv_r ? S_MCRD : S_MRD;
      S_MCRD: st_d = S_MDN;
      S_MDN:  st_d = S_MRD;
      S_OUT:  if (!out_stall_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d = res_q;
    if (st_q == S_EVAL) begin
      res_d = '0;
      if (act_q == ACT_LOOKUP) begin
        if (lv_r) begin
          res_d.page = lpg_r; res_d.hit = 1'b1;
        end else if (blk_ok && bhz_q[bidx]) begin
          res_d.page = PpW'(32'(bz[bidx]) * ZonePages + off);
        end else res_d.miss = 1'b1;
      end
      if (act_q == ACT_QUERY && 32'(zi_q) < Zones) res_d.count = CntOutW'(c_rdat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLR;
      clr_q <= '0;
      for (int i = 0; i < DataZones; i++) bhz_q[i] <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (st_q == S_MRD && st_d == S_OUT) bhz_q[bidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_CLR) lv[clr_q] <= 1'b0;
    else if (st_q == S_EVAL && act_q == ACT_WRITE && blk_ok && pz < Zones) begin
      lv[addr_q]  <= 1'b1;
      lpg[addr_q] <= pp_q;
    end else if (st_q == S_MEV) lv[addr_q] <= 1'b0;
    // hold the superseded page while its zone is decremented
    if (st_q != S_DNRD) begin
      lv_r  <= lv[addr_q];
      lpg_r <= lpg[addr_q];
    end
    if (st_q == S_MRD && st_d == S_OUT) bz[bidx] <= zi_q;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        act_q  <= action_i;
        lp_q   <= logical_page_i;
        pp_q   <= physical_page_i;
        zi_q   <= zone_index_i;
        addr_q <= LdW'(logical_page_i);
        ofs_q  <= '0;
      end
      S_EVAL: begin
        res_q  <= res_d;
        addr_q <= LdW'(blk * ZonePages);
      end
      S_MEV: begin
        if (!lv_r) begin
          addr_q <= addr_q + 1'b1;
          ofs_q  <= ofs_q + 1'b1;
        end
      end
      S_MDN: begin
        addr_q <= addr_q + 1'b1;
        ofs_q  <= ofs_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign in_stall_o    = (st_q != S_IDLE);
  assign out_valid_o   = (st_q == S_OUT);
  assign mapped_page_o = res_q.page;
  assign from_log_o    = res_q.hit;
  assign unmapped_o    = res_q.miss;
  assign valid_count_o = res_q.count;
endmodule
`default_nettype wire

### src/hlbm_zone_count.sv
//------------------------------------------------------------------------------
// hlbm_zone_count: per-zone valid page counters
// Counter memory with one saturating up/down unit; clears itself after reset.
//------------------------------------------------------------------------------
`default_nettype none
module hlbm_zone_count #(
  parameter int unsigned ZonePages = hlbm_pkg::ZonePagesDef,
  parameter int unsigned Zones     = hlbm_pkg::ZonesDef,
  parameter int unsigned ZW        = $clog2(Zones),
  parameter int unsigned CW        = $clog2(ZonePages + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_i,
  input  wire logic [ZW-1:0] rd_zone_i,
  output logic      [CW-1:0] rd_data_o,
  input  wire logic          wr_i,
  input  wire logic [ZW-1:0] wr_zone_i,
  input  wire logic          up_i,
  input  wire logic [CW-1:0] wr_old_i,
  output logic               clr_busy_o
);
  logic [CW-1:0] mem [Zones];
  logic [ZW-1:0] clr_q;
  logic          busy_q;
  logic [CW-1:0] nxt;

  always_comb begin
    nxt = wr_old_i;
    if (up_i) begin
      if (wr_old_i < CW'(ZonePages)) nxt = wr_old_i + 1'b1;
    end else begin
      if (wr_old_i != '0) nxt = wr_old_i - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == ZW'(Zones - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) mem[clr_q] <= '0;
    else if (wr_i) mem[wr_zone_i] <= nxt;
    if (rd_i) rd_data_o <= mem[rd_zone_i];
  end

  assign clr_busy_o = busy_q;
endmodule
`default_nettype wire
